@@ hw/rtl/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types, constants and twiddle table
// Widths, state encodings and the quarter-wave cosine ROM for the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int MaxLog     = 10;
  localparam int MaxPoints  = 1 << MaxLog;
  localparam int AddrW      = MaxLog;
  localparam int ValW       = 27;
  localparam int SampW      = 16;
  localparam int TwW        = 16;
  localparam int TwFrac     = TwW - 1;
  localparam int CfgW       = 4;
  localparam int RegIdxW    = 1;

  localparam logic [RegIdxW-1:0] REG_LOG2_POINTS = 1'b0;
  localparam logic [RegIdxW-1:0] REG_INVERSE     = 1'b1;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZFILL,
    ST_REV_RD,
    ST_REV_WAIT,
    ST_REV_WR,
    ST_BF_RD,
    ST_BF_WAIT,
    ST_BF_MUL,
    ST_BF_WR,
    ST_SCALE_RD,
    ST_SCALE_WAIT,
    ST_SCALE_WR,
    ST_READ_WAIT
  } state_t;

  typedef struct packed {
    logic signed [TwW-1:0] c;
    logic signed [TwW-1:0] s;
  } tw_t;

  typedef logic [TwW-1:0] cos_rom_t [0:256];

  // Integer Taylor series for cos(x), argument and result in Q2.30.
  function automatic longint cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) sum -= longint'(term);
      else sum += longint'(term);
    end
    return sum;
  endfunction

  // Quarter-wave cosine, Q1.15, entry k = cos(pi*k/512), 1.0 saturated.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t r;
    longint v;
    longint t;
    for (int k = 0; k <= 256; k++) begin
      v = cos_q30((64'd3373259426 * 64'(k)) / 64'd512);
      if (v < 0) v = 0;
      if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
      t = (v + (64'sd1 <<< (29 - TwFrac))) >>> (30 - TwFrac);
      if (t > (64'sd1 <<< TwFrac) - 1) t = (64'sd1 <<< TwFrac) - 1;
      r[k] = TwW'(t);
    end
    return r;
  endfunction

  localparam cos_rom_t CosRom = build_cos_rom();

  function automatic tw_t twiddle(input logic [AddrW-1:0] k_in);
    logic [8:0] k;
    tw_t r;
    k = k_in[8:0];
    if (k <= 9'd256) begin
      r.c = CosRom[k];
      r.s = CosRom[9'(9'd256 - k)];
    end else begin
      r.c = -CosRom[9'(10'd512 - {1'b0, k})];
      r.s = CosRom[9'(k - 9'd256)];
    end
    return r;
  endfunction

  function automatic logic [AddrW-1:0] bitrev(input logic [AddrW-1:0] i,
                                              input logic [CfgW-1:0] l);
    logic [AddrW-1:0] r;
    r = '0;
    for (int b = 0; b < AddrW; b++) begin
      if (b < int'(l)) r[int'(l) - 1 - b] = i[b];
    end
    return r;
  endfunction

  function automatic val_t sat27(input logic signed [ValW+1:0] v);
    if (v > (ValW+2)'(67108863)) return val_t'(67108863);
    if (v < -(ValW+2)'(67108864)) return val_t'(-67108864);
    return v[ValW-1:0];
  endfunction

endpackage

@@ hw/rtl/r2fft_if.sv @@
// ----------------------------------------------------------------------------
// r2fft_in_if / r2fft_out_if: valid/ready channels
// Input carries load and read requests; output carries bin results.
// ----------------------------------------------------------------------------
interface r2fft_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;
  logic        last_sample;
  logic [9:0]  bin_index;
  modport source (output valid, mode, sample_real, sample_imag, last_sample, bin_index,
                  input ready);
  modport sink (input valid, mode, sample_real, sample_imag, last_sample, bin_index,
                output ready);
endinterface

interface r2fft_out_if;
  logic        valid;
  logic        ready;
  logic signed [26:0] bin_real;
  logic signed [26:0] bin_imag;
  logic        ready_res;
  modport source (output valid, bin_real, bin_imag, ready_res, input ready);
  modport sink (input valid, bin_real, bin_imag, ready_res, output ready);
endinterface

@@ hw/rtl/r2fft_ram.sv @@
// ----------------------------------------------------------------------------
// r2fft_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/r2fft_bfly.sv @@
// ----------------------------------------------------------------------------
// r2fft_bfly: shared butterfly arithmetic
// Registered complex twiddle product, then sum and difference with saturation.
// ----------------------------------------------------------------------------
module r2fft_bfly (
  input  logic                 clk,
  input  r2fft_pkg::tw_t       tw,
  input  r2fft_pkg::val_t      xr,
  input  r2fft_pkg::val_t      xi,
  input  r2fft_pkg::val_t      ar,
  input  r2fft_pkg::val_t      ai,
  output r2fft_pkg::val_t      sum_r,
  output r2fft_pkg::val_t      sum_i,
  output r2fft_pkg::val_t      dif_r,
  output r2fft_pkg::val_t      dif_i
);
  localparam int PW = r2fft_pkg::ValW + r2fft_pkg::TwW + 1;
  logic signed [PW-1:0] pr;
  logic signed [PW-1:0] pi;
  logic signed [PW-1:0] tr_full;
  logic signed [PW-1:0] ti_full;
  logic signed [r2fft_pkg::ValW+1:0] tr;
  logic signed [r2fft_pkg::ValW+1:0] ti;
  logic signed [r2fft_pkg::ValW+1:0] arx;
  logic signed [r2fft_pkg::ValW+1:0] aix;

  // Products are registered; the rounding shift and adders follow.
  always_ff @(posedge clk) begin
    pr <= PW'(tw.c * xr) + PW'(tw.s * xi);
    pi <= PW'(tw.c * xi) - PW'(tw.s * xr);
  end

  always_comb begin
    tr_full = (pr + PW'(1 << (r2fft_pkg::TwFrac - 1))) >>> r2fft_pkg::TwFrac;
    ti_full = (pi + PW'(1 << (r2fft_pkg::TwFrac - 1))) >>> r2fft_pkg::TwFrac;
    tr  = tr_full[r2fft_pkg::ValW+1:0];
    ti  = ti_full[r2fft_pkg::ValW+1:0];
    arx = (r2fft_pkg::ValW+2)'(ar);
    aix = (r2fft_pkg::ValW+2)'(ai);
    sum_r = r2fft_pkg::sat27(arx + tr);
    sum_i = r2fft_pkg::sat27(aix + ti);
    dif_r = r2fft_pkg::sat27(arx - tr);
    dif_i = r2fft_pkg::sat27(aix - ti);
  end
endmodule

@@ hw/rtl/radix2_complex_fft_core.sv @@
// ----------------------------------------------------------------------------
// radix2_complex_fft_core: in-place radix-2 complex FFT
// Loads a frame, reorders, runs all butterfly stages, scales in inverse mode and serves bin reads.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch. mode 0 loads one Q1.15 sample in natural
// order; last_sample ends the frame, zero-fills the rest and starts the
// transform. mode 1 reads one bin and gives one beat on out_ch.
// A load that does not end a frame leaves the block ready for the next
// item. Ending a frame runs a zero-fill pass, a bit-reversal reorder that
// swaps pairs, N/2*log2N butterflies and, in inverse mode, a scaling pass;
// the single-port work memory sets the pace of each. A read waits in
// ST_READ_WAIT for the registered memory word, which then becomes its
// result beat.
// in_ch.ready is low while the transform or a read runs and while a result
// beat is held; a stalled receiver holds the beat and the block waits.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce it. Reset (rst, synchronous)
// empties the frame, drops any held result and sets the length to 1024
// points, forward mode. The work memory needs no clearing pass.
// ----------------------------------------------------------------------------
module radix2_complex_fft_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [r2fft_pkg::RegIdxW-1:0]    cfg_index,
  input  logic [r2fft_pkg::CfgW-1:0]       cfg_data,
  r2fft_in_if.sink                         in_ch,
  r2fft_out_if.source                      out_ch
);
  localparam int AW = r2fft_pkg::AddrW;
  localparam int MW = 2 * r2fft_pkg::ValW;

  r2fft_pkg::state_t state, state_next;
  logic [r2fft_pkg::CfgW-1:0] log2_points;
  logic inverse, inv_frame;
  logic [AW:0] load_count;
  logic result_held;
  logic [AW:0] idx;          // sweep index
  logic [AW:0] j;            // butterfly position in stage
  logic [r2fft_pkg::CfgW-1:0] stage;   // current stage, 1..L
  logic [AW-1:0] pa, pb;    // butterfly pair addresses
  logic phase;
  r2fft_pkg::val_t ar, ai, xr, xi;
  logic out_valid;
  r2fft_pkg::val_t out_r, out_i;
  logic out_rr;
  logic read_ok;

  logic we;
  logic [AW-1:0] addr;
  logic [MW-1:0] wdata, rdata;
  r2fft_pkg::val_t rd_r, rd_i;
  r2fft_pkg::val_t sum_r, sum_i, dif_r, dif_i;
  r2fft_pkg::tw_t tw;

  logic [AW:0] npts;
  logic [AW-1:0] half, grp, pos, tw_k;
  logic [AW-1:0] rev;
  logic accept;
  logic signed [r2fft_pkg::ValW:0] neg_i;

  assign npts   = (AW+1)'(1) << log2_points;
  assign accept = in_ch.valid && in_ch.ready;
  assign rd_r   = rdata[MW-1:r2fft_pkg::ValW];
  assign rd_i   = rdata[r2fft_pkg::ValW-1:0];
  assign in_ch.ready = (state == r2fft_pkg::ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.bin_real = out_r;
  assign out_ch.bin_imag = out_i;
  assign out_ch.ready_res = out_rr;

  r2fft_ram #(.Width(MW), .Depth(r2fft_pkg::MaxPoints)) u_work (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  r2fft_bfly u_bfly (
    .clk(clk), .tw(tw), .xr(xr), .xi(xi), .ar(ar), .ai(ai),
    .sum_r(sum_r), .sum_i(sum_i), .dif_r(dif_r), .dif_i(dif_i));

  // Butterfly j of stage l: group and position within half-span.
  always_comb begin
    half = AW'(1) << (stage - 1'b1);
    pos  = j[AW-1:0] & (half - 1'b1);
    grp  = j[AW-1:0] >> (stage - 1'b1);
    pa   = (grp << stage) | pos;
    pb   = pa | half;
    tw_k = pos << (4'(AW) - stage);
    tw   = r2fft_pkg::twiddle(tw_k);
    rev  = r2fft_pkg::bitrev(idx[AW-1:0], log2_points);
    neg_i = -(r2fft_pkg::ValW+1)'(rd_i);
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    addr = idx[AW-1:0];
    wdata = '0;
    case (state)
      r2fft_pkg::ST_IDLE: begin
        addr = in_ch.bin_index;
        if (accept && !in_ch.mode) begin
          addr = load_count[AW-1:0];
          wdata = {r2fft_pkg::ValW'(in_ch.sample_real),
                   inverse ? -r2fft_pkg::ValW'(in_ch.sample_imag)
                           :  r2fft_pkg::ValW'(in_ch.sample_imag)};
          we = (result_held ? 1'b1 : (load_count < npts));
          if (result_held) addr = '0;
          if (in_ch.last_sample) state_next = r2fft_pkg::ST_ZFILL;
        end else if (accept) begin
          state_next = r2fft_pkg::ST_READ_WAIT;
        end
      end
      r2fft_pkg::ST_ZFILL: begin
        if (idx < npts) begin
          we = 1'b1;
        end else begin
          state_next = r2fft_pkg::ST_REV_RD;
        end
      end
      r2fft_pkg::ST_REV_RD: begin
        if (idx >= npts) state_next = r2fft_pkg::ST_BF_RD;
        else if (idx[AW-1:0] < rev) begin
          addr = phase ? rev : idx[AW-1:0];
          if (phase) state_next = r2fft_pkg::ST_REV_WAIT;
        end
      end
      r2fft_pkg::ST_REV_WAIT: begin
        addr = rev;
        state_next = r2fft_pkg::ST_REV_WR;
      end
      r2fft_pkg::ST_REV_WR: begin
        we = 1'b1;
        addr = phase ? rev : idx[AW-1:0];
        wdata = phase ? {ar, ai} : {xr, xi};
        if (phase) state_next = r2fft_pkg::ST_REV_RD;
      end
      r2fft_pkg::ST_BF_RD: begin
        addr = phase ? pb : pa;
        if (phase) state_next = r2fft_pkg::ST_BF_WAIT;
      end
      r2fft_pkg::ST_BF_WAIT: begin
        addr = pb;
        state_next = r2fft_pkg::ST_BF_MUL;
      end
      r2fft_pkg::ST_BF_MUL: begin
        addr = pa;
        state_next = r2fft_pkg::ST_BF_WR;
      end
      r2fft_pkg::ST_BF_WR: begin
        we = 1'b1;
        addr = phase ? pb : pa;
        wdata = phase ? {dif_r, dif_i} : {sum_r, sum_i};
        if (phase) begin
          if (j[AW-1:0] + 1'b1 == AW'(npts >> 1)) begin
            if (stage == log2_points)
              state_next = inv_frame ? r2fft_pkg::ST_SCALE_RD : r2fft_pkg::ST_IDLE;
            else state_next = r2fft_pkg::ST_BF_RD;
          end else begin
            state_next = r2fft_pkg::ST_BF_RD;
          end
        end
      end
      r2fft_pkg::ST_SCALE_RD: begin
        if (idx >= npts) state_next = r2fft_pkg::ST_IDLE;
        else state_next = r2fft_pkg::ST_SCALE_WAIT;
      end
      r2fft_pkg::ST_SCALE_WAIT: begin
        state_next = r2fft_pkg::ST_SCALE_WR;
      end
      r2fft_pkg::ST_SCALE_WR: begin
        we = 1'b1;
        wdata = {rd_r >>> log2_points,
                 r2fft_pkg::ValW'(neg_i >>> log2_points)};
        state_next = r2fft_pkg::ST_SCALE_RD;
      end
      r2fft_pkg::ST_READ_WAIT: begin
        state_next = r2fft_pkg::ST_IDLE;
      end
      default: state_next = r2fft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2fft_pkg::ST_IDLE;
      log2_points <= r2fft_pkg::CfgW'(r2fft_pkg::MaxLog);
      inverse <= 1'b0;
      inv_frame <= 1'b0;
      load_count <= '0;
      result_held <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
      j <= '0;
      stage <= 4'd1;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cfg_we && cfg_index == r2fft_pkg::REG_LOG2_POINTS) begin
        if (cfg_data == '0) log2_points <= 4'd1;
        else if (cfg_data > r2fft_pkg::CfgW'(r2fft_pkg::MaxLog))
          log2_points <= r2fft_pkg::CfgW'(r2fft_pkg::MaxLog);
        else log2_points <= cfg_data;
        load_count <= '0;
        result_held <= 1'b0;
      end
      if (cfg_we && cfg_index == r2fft_pkg::REG_INVERSE) inverse <= cfg_data[0];
      case (state)
        r2fft_pkg::ST_IDLE: begin
          phase <= 1'b0;
          if (accept && !in_ch.mode) begin
            if (result_held) begin
              result_held <= 1'b0;
              load_count <= (AW+1)'(1);
              idx <= (AW+1)'(1);
            end else if (load_count < npts) begin
              load_count <= load_count + 1'b1;
              idx <= load_count + 1'b1;
            end else begin
              idx <= load_count;
            end
            if (in_ch.last_sample) inv_frame <= inverse;
          end
          if (accept && in_ch.mode) read_ok <= result_held && ({1'b0, in_ch.bin_index} < npts);
        end
        r2fft_pkg::ST_ZFILL: begin
          if (idx < npts) idx <= idx + 1'b1;
          else idx <= '0;
        end
        r2fft_pkg::ST_REV_RD: begin
          if (idx >= npts) begin
            j <= '0;
            stage <= 4'd1;
            phase <= 1'b0;
          end else if (idx[AW-1:0] < rev) begin
            // Read data of the lower address is captured while the higher address is read.
            if (phase) begin
              ar <= rd_r; ai <= rd_i;
            end
            phase <= !phase;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        r2fft_pkg::ST_REV_WAIT: begin
          xr <= rd_r; xi <= rd_i;
          phase <= 1'b0;
        end
        r2fft_pkg::ST_REV_WR: begin
          if (phase) idx <= idx + 1'b1;
          phase <= !phase;
        end
        r2fft_pkg::ST_BF_RD: begin
          if (phase) begin
            ar <= rd_r; ai <= rd_i;
          end
          phase <= !phase;
        end
        r2fft_pkg::ST_BF_WAIT: begin
          xr <= rd_r; xi <= rd_i;
        end
        r2fft_pkg::ST_BF_MUL: begin
          phase <= 1'b0;
        end
        r2fft_pkg::ST_BF_WR: begin
          phase <= !phase;
          if (phase) begin
            if (j[AW-1:0] + 1'b1 == AW'(npts >> 1)) begin
              j <= '0;
              stage <= stage + 1'b1;
              if (stage == log2_points) begin
                idx <= '0;
                if (!inv_frame) begin
                  result_held <= 1'b1;
                  load_count <= '0;
                end
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        r2fft_pkg::ST_SCALE_RD: begin
          if (idx >= npts) begin
            result_held <= 1'b1;
            load_count <= '0;
          end
        end
        r2fft_pkg::ST_SCALE_WR: idx <= idx + 1'b1;
        r2fft_pkg::ST_READ_WAIT: begin
          out_valid <= 1'b1;
          out_rr <= result_held;
          out_r <= read_ok ? rd_r : '0;
          out_i <= read_ok ? rd_i : '0;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No new item may enter while a result beat waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready) else $error("accept while result pending");
  // Length register always stays in range.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (log2_points >= 4'd1) && (log2_points <= 4'(r2fft_pkg::MaxLog)))
    else $error("length out of range");
  // A read request passes through ST_READ_WAIT before its result beat is presented.
  a_read_lat: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.mode) |=> ##1 out_valid)
    else $error("read sequencing broken");
  // Bins of an absent result read as zero.
  a_zero_bins: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_rr) |-> (out_r == '0 && out_i == '0))
    else $error("nonzero bin without result");
`endif
endmodule
